// ----- hdl/dqpb_pkg.sv -----
// Shared types and constants for the DNS query packet builder.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package dqpb_pkg;

    // Input action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_CHAR  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NAME_LONG  = 2'd1;
    localparam logic [1:0] ST_LABEL_LONG = 2'd2;

    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] QCLASS_IN  = 8'd1;
    localparam logic [7:0] QDCOUNT_LO = 8'd1;

    // Field widths that the message format fixes
    localparam int LEN_W      = 6;   // label length, holds up to 63
    localparam int NAME_CNT_W = 9;   // name character count
    localparam int CMDQ_DEPTH = 4;   // command queue entries

    // Byte positions inside the fixed header and trailer
    localparam logic [LEN_W-1:0] HDR_ID_HI   = 6'd0;
    localparam logic [LEN_W-1:0] HDR_ID_LO   = 6'd1;
    localparam logic [LEN_W-1:0] HDR_FLAGS   = 6'd2;
    localparam logic [LEN_W-1:0] HDR_QD_LO   = 6'd5;
    localparam logic [LEN_W-1:0] HDR_LAST    = 6'd11;
    localparam logic [LEN_W-1:0] TRL_QT_HI   = 6'd1;
    localparam logic [LEN_W-1:0] TRL_QT_LO   = 6'd2;
    localparam logic [LEN_W-1:0] TRL_LAST    = 6'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] packet_id;
        logic [15:0] query_type;
        logic        recursion_desired;
        logic [7:0]  name_char;
    } item_t;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [1:0] byte_count;
        logic       run_end;
        logic       packet_end;
        logic [1:0] status;
    } result_t;

    typedef enum logic [1:0] {
        CMD_HEAD,
        CMD_LABEL,
        CMD_TAIL,
        CMD_FAIL
    } cmd_kind_t;

    // One classified unit of work for the byte sequencer
    typedef struct packed {
        cmd_kind_t        kind;
        logic [1:0]       status;
        logic             has_label;
        logic [LEN_W-1:0] len;
        logic [15:0]      data16;   // packet ID for a header, QTYPE for a trailer
        logic             rd;
    } cmd_t;

    // Label memory write port
    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

endpackage

// ----- hdl/dqpb_front.sv -----
// Front end: accepts input beats, tracks name and label state, writes label characters
// and turns start, dot, end and error beats into queue commands. Depends on dqpb_pkg.
module dqpb_front #(
    parameter int MAX_NAME_LEN  = 255,
    parameter int MAX_LABEL_LEN = 63
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  dqpb_pkg::item_t    item,
    input  logic               fifo_full,
    input  logic               label_done,
    output logic               cmd_push,
    output dqpb_pkg::cmd_t     cmd,
    output dqpb_pkg::store_wr_t store_wr
);

    typedef enum logic {
        PH_IDLE,
        PH_NAME
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [dqpb_pkg::LEN_W-1:0]         label_count_reg, label_count_next;
    logic                               label_ovf_reg, label_ovf_next;
    logic                               label_open_reg, label_open_next;
    logic [dqpb_pkg::NAME_CNT_W-1:0]    name_count_reg, name_count_next;
    logic [15:0]                        qtype_reg, qtype_next;
    logic                               label_busy_reg, label_busy_next;
    logic                               accept;

    // Stall while a label replays out of the shared store or the command queue is full
    assign item_ready = !fifo_full && !label_busy_reg;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        phase_next       = phase_reg;
        label_count_next = label_count_reg;
        label_ovf_next   = label_ovf_reg;
        label_open_next  = label_open_reg;
        name_count_next  = name_count_reg;
        qtype_next       = qtype_reg;
        label_busy_next  = label_busy_reg && !label_done;
        cmd_push         = 1'b0;
        cmd              = '0;
        store_wr         = '0;

        if (accept)
        begin
            if (item.action == dqpb_pkg::ACT_START)
            begin
                phase_next       = PH_NAME;
                label_count_next = '0;
                label_ovf_next   = 1'b0;
                label_open_next  = 1'b0;
                name_count_next  = '0;
                qtype_next       = item.query_type;
                cmd_push         = 1'b1;
                cmd.kind         = dqpb_pkg::CMD_HEAD;
                cmd.data16       = item.packet_id;
                cmd.rd           = item.recursion_desired;
            end
            else if (phase_reg == PH_NAME)
            begin
                unique case (item.action)
                    dqpb_pkg::ACT_CHAR:
                    begin
                        if (name_count_reg > dqpb_pkg::NAME_CNT_W'(MAX_NAME_LEN))
                        begin
                            cmd_push         = 1'b1;
                            cmd.kind         = dqpb_pkg::CMD_FAIL;
                            cmd.status       = dqpb_pkg::ST_NAME_LONG;
                            phase_next       = PH_IDLE;
                            label_count_next = '0;
                            label_ovf_next   = 1'b0;
                            label_open_next  = 1'b0;
                        end
                        else
                        begin
                            if (name_count_reg != '1)
                            begin
                                name_count_next = name_count_reg + 1'b1;
                            end
                            if (item.name_char != dqpb_pkg::DOT_CHAR)
                            begin
                                if (label_count_reg < dqpb_pkg::LEN_W'(MAX_LABEL_LEN))
                                begin
                                    store_wr.en      = 1'b1;
                                    store_wr.addr    = label_count_reg;
                                    store_wr.data    = item.name_char;
                                    label_count_next = label_count_reg + 1'b1;
                                end
                                else
                                begin
                                    label_ovf_next = 1'b1;
                                end
                                label_open_next = 1'b1;
                            end
                            else
                            begin
                                cmd_push         = 1'b1;
                                label_count_next = '0;
                                label_ovf_next   = 1'b0;
                                label_open_next  = 1'b0;
                                if (label_ovf_reg)
                                begin
                                    cmd.kind   = dqpb_pkg::CMD_FAIL;
                                    cmd.status = dqpb_pkg::ST_LABEL_LONG;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    cmd.kind        = dqpb_pkg::CMD_LABEL;
                                    cmd.has_label   = 1'b1;
                                    cmd.len         = label_count_reg;
                                    label_busy_next = 1'b1;
                                end
                            end
                        end
                    end
                    dqpb_pkg::ACT_END:
                    begin
                        cmd_push         = 1'b1;
                        phase_next       = PH_IDLE;
                        label_count_next = '0;
                        label_ovf_next   = 1'b0;
                        label_open_next  = 1'b0;
                        if (label_open_reg && label_ovf_reg)
                        begin
                            cmd.kind   = dqpb_pkg::CMD_FAIL;
                            cmd.status = dqpb_pkg::ST_LABEL_LONG;
                        end
                        else
                        begin
                            cmd.kind        = dqpb_pkg::CMD_TAIL;
                            cmd.has_label   = label_open_reg;
                            cmd.len         = label_count_reg;
                            cmd.data16      = qtype_reg;
                            label_busy_next = label_open_reg;
                        end
                    end
                    default:
                    begin
                        // unknown action: drop
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            label_count_reg <= '0;
            label_ovf_reg   <= 1'b0;
            label_open_reg  <= 1'b0;
            name_count_reg  <= '0;
            qtype_reg       <= '0;
            label_busy_reg  <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            label_count_reg <= label_count_next;
            label_ovf_reg   <= label_ovf_next;
            label_open_reg  <= label_open_next;
            name_count_reg  <= name_count_next;
            qtype_reg       <= qtype_next;
            label_busy_reg  <= label_busy_next;
        end
    end

endmodule

// ----- hdl/dqpb_cmd_fifo.sv -----
// Short command queue between the front end and the byte sequencer.
// Depends on dqpb_pkg for the command type and depth.
module dqpb_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dqpb_pkg::cmd_t din,
    input  logic           pop,
    output dqpb_pkg::cmd_t dout,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = $clog2(dqpb_pkg::CMDQ_DEPTH);
    localparam int CNT_W = $clog2(dqpb_pkg::CMDQ_DEPTH + 1);

    dqpb_pkg::cmd_t    entry_reg [dqpb_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(dqpb_pkg::CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- hdl/dqpb_back.sv -----
// Back end: byte sequencer replays header, labels and trailer one byte a cycle unless
// stalled; pairs bytes into results held in an output register. Depends on dqpb_pkg.
module dqpb_back #(
    parameter int MAX_LABEL_LEN = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dqpb_pkg::cmd_t      head,
    input  logic                empty,
    output logic                pop,
    output logic                label_done,
    input  dqpb_pkg::store_wr_t store_wr,
    output logic                result_valid,
    input  logic                result_ready,
    output dqpb_pkg::result_t   result
);

    localparam int ADDR_W = $clog2(MAX_LABEL_LEN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_LABEL,
        S_TAIL,
        S_FAIL
    } state_t;

    // One byte on its way from the issue stage to the pairing stage
    typedef struct packed {
        logic [7:0] byte_val;
        logic       use_mem;
        logic       last;
        logic       pkt_end;
        logic       fail;
        logic [1:0] status;
    } byte_item_t;

    logic [7:0]                 store_mem [MAX_LABEL_LEN];
    logic [7:0]                 rd_q;
    logic [ADDR_W-1:0]          rd_addr;
    logic [dqpb_pkg::LEN_W-1:0] pos_m1;

    state_t                     state_reg, state_next;
    logic [dqpb_pkg::LEN_W-1:0] pos_reg, pos_next;
    dqpb_pkg::cmd_t             cmd_reg, cmd_next;
    byte_item_t                 s2_reg, s2_next, iss;
    logic                       s2_valid_reg, s2_valid_next;
    logic [7:0]                 half_reg, half_next;
    logic                       half_valid_reg, half_valid_next;
    dqpb_pkg::result_t          out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       go;
    logic [7:0]                 cur_byte;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign go           = !out_valid_reg || result_ready;
    assign pos_m1       = pos_reg - 1'b1;
    assign cur_byte     = s2_reg.use_mem ? rd_q : s2_reg.byte_val;

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        cmd_next        = cmd_reg;
        s2_next         = s2_reg;
        s2_valid_next   = s2_valid_reg;
        half_next       = half_reg;
        half_valid_next = half_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pop             = 1'b0;
        label_done      = 1'b0;
        rd_addr         = '0;
        iss             = '0;

        if (go)
        begin
            // issue stage: pick the next byte of the current command
            s2_valid_next = 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        pop      = 1'b1;
                        cmd_next = head;
                        pos_next = '0;
                        unique case (head.kind)
                            dqpb_pkg::CMD_HEAD:  state_next = S_HEAD;
                            dqpb_pkg::CMD_LABEL: state_next = S_LABEL;
                            dqpb_pkg::CMD_TAIL:  state_next = head.has_label ? S_LABEL : S_TAIL;
                            dqpb_pkg::CMD_FAIL:  state_next = S_FAIL;
                            default:             state_next = S_IDLE;
                        endcase
                    end
                end
                S_HEAD:
                begin
                    s2_valid_next = 1'b1;
                    case (pos_reg)
                        dqpb_pkg::HDR_ID_HI: iss.byte_val = cmd_reg.data16[15:8];
                        dqpb_pkg::HDR_ID_LO: iss.byte_val = cmd_reg.data16[7:0];
                        dqpb_pkg::HDR_FLAGS: iss.byte_val = {7'd0, cmd_reg.rd};
                        dqpb_pkg::HDR_QD_LO: iss.byte_val = dqpb_pkg::QDCOUNT_LO;
                        default:             iss.byte_val = 8'd0;
                    endcase
                    if (pos_reg == dqpb_pkg::HDR_LAST)
                    begin
                        iss.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                S_LABEL:
                begin
                    s2_valid_next = 1'b1;
                    if (pos_reg == '0)
                    begin
                        iss.byte_val = {{(8 - dqpb_pkg::LEN_W){1'b0}}, cmd_reg.len};
                    end
                    else
                    begin
                        iss.use_mem = 1'b1;
                        rd_addr     = pos_m1[ADDR_W-1:0];
                    end
                    if (pos_reg == cmd_reg.len)
                    begin
                        label_done = 1'b1;
                        pos_next   = '0;
                        if (cmd_reg.kind == dqpb_pkg::CMD_TAIL)
                        begin
                            state_next = S_TAIL;
                        end
                        else
                        begin
                            iss.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                S_TAIL:
                begin
                    s2_valid_next = 1'b1;
                    case (pos_reg)
                        dqpb_pkg::TRL_QT_HI: iss.byte_val = cmd_reg.data16[15:8];
                        dqpb_pkg::TRL_QT_LO: iss.byte_val = cmd_reg.data16[7:0];
                        dqpb_pkg::TRL_LAST:  iss.byte_val = dqpb_pkg::QCLASS_IN;
                        default:             iss.byte_val = 8'd0;
                    endcase
                    if (pos_reg == dqpb_pkg::TRL_LAST)
                    begin
                        iss.last    = 1'b1;
                        iss.pkt_end = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                S_FAIL:
                begin
                    s2_valid_next = 1'b1;
                    iss.fail      = 1'b1;
                    iss.last      = 1'b1;
                    iss.pkt_end   = 1'b1;
                    iss.status    = cmd_reg.status;
                    state_next    = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
            s2_next = iss;

            // pairing stage: combine bytes into results
            out_valid_next = 1'b0;
            if (s2_valid_reg)
            begin
                if (s2_reg.fail)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = '0;
                    out_next.run_end    = 1'b1;
                    out_next.packet_end = 1'b1;
                    out_next.status     = s2_reg.status;
                    half_valid_next = 1'b0;
                end
                else if (half_valid_reg)
                begin
                    out_valid_next          = 1'b1;
                    out_next.first_byte     = half_reg;
                    out_next.second_byte    = cur_byte;
                    out_next.byte_count     = 2'd2;
                    out_next.run_end        = s2_reg.last;
                    out_next.packet_end     = s2_reg.last && s2_reg.pkt_end;
                    out_next.status         = dqpb_pkg::ST_OK;
                    half_valid_next         = 1'b0;
                end
                else if (s2_reg.last)
                begin
                    out_valid_next          = 1'b1;
                    out_next.first_byte     = cur_byte;
                    out_next.second_byte    = 8'd0;
                    out_next.byte_count     = 2'd1;
                    out_next.run_end        = 1'b1;
                    out_next.packet_end     = s2_reg.pkt_end;
                    out_next.status         = dqpb_pkg::ST_OK;
                end
                else
                begin
                    half_next       = cur_byte;
                    half_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            cmd_reg        <= '0;
            s2_reg         <= '0;
            s2_valid_reg   <= 1'b0;
            half_reg       <= '0;
            half_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            cmd_reg        <= cmd_next;
            s2_reg         <= s2_next;
            s2_valid_reg   <= s2_valid_next;
            half_reg       <= half_next;
            half_valid_reg <= half_valid_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Label store: one write port from the front end, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[store_wr.addr[ADDR_W-1:0]] <= store_wr.data;
        end
        if (go)
        begin
            rd_q <= store_mem[rd_addr];
        end
    end

endmodule

// ----- hdl/dns_query_packet_builder_top.sv -----
// DNS query packet builder: start beat -> 12-byte header, name characters -> length-prefixed
// labels, end beat -> terminator, QTYPE and QCLASS; results carry up to two bytes each.
// The sequencer pops a command, then replays its bytes one per cycle while the output is
// not stalled; input stalls while a closed label replays from the label store or the
// command queue is full. Reset (rst_n, async low) clears all registers except the label
// store, the command queue entries and the store read data.
module dns_query_packet_builder_top #(
    parameter int MAX_NAME_LEN  = 255,
    parameter int MAX_LABEL_LEN = 63
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  dqpb_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output dqpb_pkg::result_t result
);

    dqpb_pkg::cmd_t      cmd_in;
    dqpb_pkg::cmd_t      cmd_head;
    dqpb_pkg::store_wr_t store_wr;
    logic                cmd_push;
    logic                cmd_pop;
    logic                fifo_full;
    logic                fifo_empty;
    logic                label_done;

    // Front end: classify beats, hold name/label counters, fill the label store
    dqpb_front #(
        .MAX_NAME_LEN  (MAX_NAME_LEN),
        .MAX_LABEL_LEN (MAX_LABEL_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .fifo_full  (fifo_full),
        .label_done (label_done),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in),
        .store_wr   (store_wr)
    );

    // Command queue decouples classification from byte replay
    dqpb_cmd_fifo u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    // Back end: replay bytes, pair them, hold the result beat until taken
    dqpb_back #(
        .MAX_LABEL_LEN (MAX_LABEL_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (cmd_head),
        .empty        (fifo_empty),
        .pop          (cmd_pop),
        .label_done   (label_done),
        .store_wr     (store_wr),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // A command is never pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> !fifo_full)
        else $error("command pushed into full queue");

    // An error beat carries no bytes and closes both run and packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != dqpb_pkg::ST_OK) |->
        (result.byte_count == 2'd0 && result.run_end && result.packet_end))
        else $error("error beat malformed");

    // A packet end beat is always the last beat of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.packet_end) |-> result.run_end)
        else $error("packet end without run end");

endmodule
